### hdl/rau_pkg.sv
package rau_pkg;

  localparam int DefValueWidth = 32;
  localparam int FieldWidth    = 32;
  localparam int MagWidth      = 64;

  typedef enum logic [2:0] {
    KIND_NORM = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_CMP  = 3'd5
  } kind_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;

  localparam logic [1:0] ORDER_LESS  = 2'd0;
  localparam logic [1:0] ORDER_EQUAL = 2'd1;
  localparam logic [1:0] ORDER_MORE  = 2'd2;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]          kind;
    logic                zero_den;
    logic [FieldWidth-1:0] a_num;
    logic [FieldWidth-1:0] a_den;
    logic [FieldWidth-1:0] b_num;
    logic [FieldWidth-1:0] b_den;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

### hdl/rau_front.sv
module rau_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    kind,
  input  logic [31:0]   a_num,
  input  logic [31:0]   a_den,
  input  logic [31:0]   b_num,
  input  logic [31:0]   b_den,
  output logic          busy,
  output logic          q_valid,
  output rau_pkg::item_t q_item,
  input  logic          q_pop
);

  // Two-entry queue between the classifier and the back part.
  rau_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic [2:0] kind_n;
  rau_pkg::item_t item_in;

  assign busy = (count == 2'd2);
  assign push = start && !busy;

  always_comb begin
    kind_n = (kind > 3'd5) ? rau_pkg::KIND_NORM : kind;
    item_in.kind    = kind_n;
    item_in.a_num   = a_num;
    item_in.a_den   = a_den;
    item_in.b_num   = b_num;
    item_in.b_den   = b_den;
    item_in.zero_den = (a_den == '0) ||
                       ((kind_n != rau_pkg::KIND_NORM) && (b_den == '0)) ||
                       ((kind_n == rau_pkg::KIND_DIV) && (b_num == '0));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

endmodule

### hdl/rau_back.sv
module rau_back #(
  parameter int VALUE_WIDTH = rau_pkg::DefValueWidth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rau_pkg::item_t q_item,
  output logic          q_pop,
  output logic          done,
  output logic [31:0]   res_num,
  output logic [30:0]   res_den,
  output logic [1:0]    status,
  output logic [1:0]    order
);

  localparam int MW = rau_pkg::MagWidth;
  localparam logic [MW-1:0] Lim = MW'(1) << (VALUE_WIDTH - 1);

  rau_pkg::back_state_t state, state_next;

  rau_pkg::item_t it;
  logic [MW-1:0] p0, p1, n_mag, d_mag, gx, gy, rem, quo, dividend, dvs;
  logic          p0_neg, p1_neg, n_neg, d_neg;
  logic [6:0]    bit_cnt;
  logic          div_second;
  logic [MW-1:0] nm_q;

  // 32x32 multiplier shared between the ST_MUL1 and ST_MUL2 states.
  logic [31:0] ma, mb;
  logic        ma_neg, mb_neg;
  logic [MW-1:0] mprod;

  function automatic logic [32:0] sm(input logic [31:0] v);
    sm = v[31] ? {1'b1, 32'(~v + 32'd1)} : {1'b0, v};
  endfunction

  logic [32:0] an_s, ad_s, bn_s, bd_s;
  assign an_s = sm(it.a_num);
  assign ad_s = sm(it.a_den);
  assign bn_s = sm(it.b_num);
  assign bd_s = sm(it.b_den);

  // Magnitude of 0x80000000 is 2^31, which fits 32 bits when unsigned.
  always_comb begin
    ma = '0; mb = '0; ma_neg = 1'b0; mb_neg = 1'b0;
    if (state == rau_pkg::ST_MUL1) begin
      case (it.kind)
        rau_pkg::KIND_MUL: begin
          {ma_neg, ma} = an_s; {mb_neg, mb} = bn_s;
        end
        default: begin
          {ma_neg, ma} = an_s; {mb_neg, mb} = bd_s;
        end
      endcase
    end else begin
      case (it.kind)
        rau_pkg::KIND_DIV: begin
          {ma_neg, ma} = ad_s; {mb_neg, mb} = bn_s;
        end
        rau_pkg::KIND_MUL: begin
          {ma_neg, ma} = ad_s; {mb_neg, mb} = bd_s;
        end
        default: begin
          {ma_neg, ma} = bn_s; {mb_neg, mb} = ad_s;
        end
      endcase
    end
  end
  assign mprod = MW'(ma) * MW'(mb);

  // Sum of the two cross products in sign-magnitude; p1 is negated for subtract and compare.
  logic [MW:0] sum_mag;
  logic        sum_neg, t_neg;
  always_comb begin
    t_neg = (it.kind == rau_pkg::KIND_SUB || it.kind == rau_pkg::KIND_CMP)
            ? ((p1 != '0) && !p1_neg) : p1_neg;
    if (p0_neg == t_neg) begin
      sum_mag = {1'b0, p0} + {1'b0, p1};
      sum_neg = p0_neg;
    end else if (p0 >= p1) begin
      sum_mag = {1'b0, p0 - p1};
      sum_neg = p0_neg;
    end else begin
      sum_mag = {1'b0, p1 - p0};
      sum_neg = t_neg;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // Restoring divide step: one quotient bit per cycle.
  logic [MW:0] rem_sh;
  logic        sub_ok;
  assign rem_sh = {rem, dividend[MW-1]};
  assign sub_ok = rem_sh >= {1'b0, dvs};

  // The gcd loop is finished once the remainder is zero; gx is zero only in
  // the first gcd cycle, before the operands are loaded.
  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::ST_IDLE:
        if (q_valid) state_next = q_item.zero_den ? rau_pkg::ST_DONE :
                                  rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1: state_next = (it.kind == rau_pkg::KIND_NORM) ?
                                     rau_pkg::ST_SUM : rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2: state_next = rau_pkg::ST_SUM;
      rau_pkg::ST_SUM:
        state_next = (it.kind == rau_pkg::KIND_CMP) ? rau_pkg::ST_DONE :
                     rau_pkg::ST_GCD;
      rau_pkg::ST_GCD:
        if (n_mag == '0) state_next = rau_pkg::ST_DONE;
        else if (gy == '0 && gx != '0) state_next = rau_pkg::ST_DIV;
      rau_pkg::ST_DIV:
        if (bit_cnt == 7'd0 && div_second) state_next = rau_pkg::ST_DONE;
      rau_pkg::ST_DONE: state_next = rau_pkg::ST_IDLE;
      default: state_next = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == rau_pkg::ST_IDLE) && q_valid;
    done  = (state == rau_pkg::ST_DONE);
  end

  logic gcd_run;
  assign gcd_run = (state == rau_pkg::ST_GCD) && (n_mag != '0) && (gy != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::ST_IDLE: begin
        it      <= q_item;
        status  <= q_item.zero_den ? rau_pkg::STATUS_ZERO : rau_pkg::STATUS_OK;
        order   <= rau_pkg::ORDER_LESS;
        res_num <= '0;
        res_den <= 31'd1;
      end
      rau_pkg::ST_MUL1: begin
        if (it.kind == rau_pkg::KIND_NORM) begin
          n_mag <= MW'(an_s[31:0]); n_neg <= an_s[32];
          d_mag <= MW'(ad_s[31:0]); d_neg <= ad_s[32];
        end
        p0     <= mprod;
        p0_neg <= (mprod != '0) && (ma_neg != mb_neg);
      end
      rau_pkg::ST_MUL2: begin
        p1     <= mprod;
        p1_neg <= (mprod != '0) && (ma_neg != mb_neg);
        d_mag  <= MW'(ad_s[31:0]) * MW'(bd_s[31:0]);
        d_neg  <= ad_s[32] != bd_s[32];
      end
      rau_pkg::ST_SUM: begin
        case (it.kind)
          rau_pkg::KIND_NORM: ;
          rau_pkg::KIND_MUL: begin
            n_mag <= p0; n_neg <= p0_neg;
            d_mag <= p1; d_neg <= p1_neg;
          end
          rau_pkg::KIND_DIV: begin
            n_mag <= p0; n_neg <= p0_neg;
            d_mag <= p1; d_neg <= p1_neg;
          end
          default: begin
            n_mag <= sum_mag[MW-1:0]; n_neg <= sum_neg;
          end
        endcase
        if (it.kind == rau_pkg::KIND_CMP) begin
          if (sum_mag == '0) order <= rau_pkg::ORDER_EQUAL;
          else order <= (sum_neg != d_neg) ? rau_pkg::ORDER_LESS :
                                              rau_pkg::ORDER_MORE;
        end
        gx <= '0;
        gy <= '0;
        bit_cnt <= 7'd0;
      end
      rau_pkg::ST_GCD: begin
        if (gx == '0 && gy == '0 && bit_cnt == 7'd0) begin
          gx <= n_mag; gy <= d_mag;
          bit_cnt <= 7'(MW);
          div_second <= 1'b0;
          dividend <= n_mag; dvs <= d_mag; rem <= '0;
        end else if (gcd_run) begin
          // Each remainder is one long division of gx by gy.
          if (bit_cnt != 7'd0) begin
            rem      <= sub_ok ? MW'(rem_sh - {1'b0, dvs}) : rem_sh[MW-1:0];
            dividend <= dividend << 1;
            bit_cnt  <= bit_cnt - 7'd1;
          end else begin
            gx <= gy; gy <= rem;
            dividend <= gy; dvs <= rem; rem <= '0;
            bit_cnt <= 7'(MW);
          end
        end else if (gy == '0) begin
          dividend <= n_mag; dvs <= gx; rem <= '0; quo <= '0;
          bit_cnt <= 7'(MW);
          div_second <= 1'b0;
        end
      end
      rau_pkg::ST_DIV: begin
        if (bit_cnt != 7'd0) begin
          rem      <= sub_ok ? MW'(rem_sh - {1'b0, dvs}) : rem_sh[MW-1:0];
          quo      <= {quo[MW-2:0], sub_ok};
          dividend <= dividend << 1;
          bit_cnt  <= bit_cnt - 7'd1;
        end else if (!div_second) begin
          nm_q <= quo;
          dividend <= d_mag; dvs <= gx; rem <= '0; quo <= '0;
          bit_cnt <= 7'(MW);
          div_second <= 1'b1;
        end else begin
          if (((n_neg != d_neg) ? (nm_q > Lim) : (nm_q >= Lim)) || quo >= Lim) begin
            status <= rau_pkg::STATUS_OVF;
          end else begin
            res_num <= (n_neg != d_neg) ? 32'(~nm_q + MW'(1)) : nm_q[31:0];
            res_den <= quo[30:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit.
// Give kind and the two fractions a_num/a_den and b_num/b_den with start high.
// The item is taken at a rising edge where start is high and busy is low.
// Kinds: normalize a, add, subtract, multiply, divide, and exact compare.
// One result per item appears on res_num, res_den, status and order, marked
// by done, which is high for exactly one cycle; the receiver cannot stall it.
// A front part classifies items (zero denominators, unused kinds) and puts
// them in a two-entry queue; the back part does the work one item at a time.
// The back part forms the 32x32 cross products in ST_MUL1 and ST_MUL2 and the
// signed sum in ST_SUM, then runs the Euclidean gcd with a one-bit-per-cycle
// divider, one long division per remainder step, then two divisions by the
// gcd. Zero-denominator items skip the work, compares end after the sum;
// the gcd's remainder count sets the rest, so latency is data dependent.
// busy is high only while the queue is full.
// Reset is synchronous: it empties the queue and returns the back part to idle.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = rau_pkg::DefValueWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        done,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  status,
  output logic [1:0]  order
);

  logic           q_valid;
  logic           q_pop;
  rau_pkg::item_t q_item;

  rau_front u_front (
    .clk(clk), .rst(rst), .start(start), .kind(kind),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .busy(busy), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .done(done), .res_num(res_num), .res_den(res_den),
    .status(status), .order(order)
  );

`ifndef SYNTH
  // A result is never shown in two adjacent cycles.
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  // The back part only pops when something is queued.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  // A reported denominator is never zero.
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    done |-> res_den != '0) else $error("zero result denominator");
`endif

endmodule

### tb/rational_arithmetic_unit_test.sv
module rational_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The two kind codes past compare are spare; the block treats them as normalize.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // The gcd divider runs one long division for each remainder step, and a wide
  // gcd can take close to ninety steps.
  localparam longint CycleLimit = 40_000_000;
  localparam int DrainCycles = 8000;

  // One expected or observed result item.
  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  status;
    logic [1:0]  order;
  } fraction_t;

  // Signed magnitude with room for exact cross products and their sums.
  typedef struct {
    bit        neg;
    bit [63:0] mag;
  } signed_mag_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  kind;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  logic        done;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;
  logic [1:0]  order;

  fraction_t pending_results[$];
  longint    cycle_count;
  int        mismatch_count;
  int        items_sent;
  int        results_seen;
  int        zero_den_seen;
  int        overflow_seen;
  int        kind_seen[8];

  rational_arithmetic_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .kind    (kind),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .done    (done),
    .res_num (res_num),
    .res_den (res_den),
    .status  (status),
    .order   (order)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Inputs are read as 32-bit two's complement, whatever VALUE_WIDTH is.
  function automatic signed_mag_t field_mag(logic [31:0] v);
    signed_mag_t r;
    r.neg = v[31];
    r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    return r;
  endfunction

  function automatic signed_mag_t mag_mul(signed_mag_t x, signed_mag_t y);
    signed_mag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic signed_mag_t mag_add(signed_mag_t x, signed_mag_t y);
    signed_mag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic signed_mag_t mag_negate(signed_mag_t x);
    signed_mag_t r;
    r = x;
    r.neg = (x.mag != 0) && !x.neg;
    return r;
  endfunction

  // Computes the reduced fraction, status and order that the block must give.
  function automatic fraction_t reduced_fraction(logic [2:0] k, logic [31:0] an_f,
                                                 logic [31:0] ad_f, logic [31:0] bn_f,
                                                 logic [31:0] bd_f);
    fraction_t   r;
    signed_mag_t an, ad, bn, bd, n, d;
    bit [63:0]   x, y, t, nm, dm;
    bit [63:0]   lim;
    bit          neg;
    an = field_mag(an_f);
    ad = field_mag(ad_f);
    bn = field_mag(bn_f);
    bd = field_mag(bd_f);
    lim = 64'd1 << 31;
    r.num = '0;
    r.den = 31'd1;
    r.status = rau_pkg::STATUS_OK;
    r.order = rau_pkg::ORDER_LESS;
    if (k > rau_pkg::KIND_CMP) k = rau_pkg::KIND_NORM;
    if (ad.mag == 0 || (k != rau_pkg::KIND_NORM && bd.mag == 0) ||
        (k == rau_pkg::KIND_DIV && bn.mag == 0)) begin
      r.status = rau_pkg::STATUS_ZERO;
    end else if (k == rau_pkg::KIND_CMP) begin
      // Exact compare: sign of the cross difference times the sign of the
      // denominator product.
      n = mag_add(mag_mul(an, bd), mag_negate(mag_mul(bn, ad)));
      d = mag_mul(ad, bd);
      if (n.mag == 0) r.order = rau_pkg::ORDER_EQUAL;
      else r.order = (n.neg != d.neg) ? rau_pkg::ORDER_LESS : rau_pkg::ORDER_MORE;
    end else begin
      case (k)
        rau_pkg::KIND_NORM: begin
          n = an;
          d = ad;
        end
        rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
          t = 0;
          n = mag_mul(bn, ad);
          if (k == rau_pkg::KIND_SUB) n = mag_negate(n);
          n = mag_add(mag_mul(an, bd), n);
          d = mag_mul(ad, bd);
        end
        rau_pkg::KIND_MUL: begin
          n = mag_mul(an, bn);
          d = mag_mul(ad, bd);
        end
        default: begin
          n = mag_mul(an, bd);
          d = mag_mul(ad, bn);
        end
      endcase
      if (n.mag != 0) begin
        x = n.mag;
        y = d.mag;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        nm = n.mag / x;
        dm = d.mag / x;
        neg = (n.neg != d.neg);
        // A negative numerator may reach -2^31; a positive one may not.
        if ((neg ? (nm > lim) : (nm >= lim)) || dm >= lim) begin
          r.status = rau_pkg::STATUS_OVF;
        end else begin
          r.num = neg ? (32'd0 - nm[31:0]) : nm[31:0];
          r.den = dm[30:0];
        end
      end
    end
    return r;
  endfunction

  // Presents one item from a falling edge and holds it until the block takes
  // it. start is left high so that a back-to-back item needs no extra edge.
  task automatic send_item(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    fraction_t want;
    want = reduced_fraction(k, an, ad, bn, bd);
    @(negedge clk);
    start <= 1'b1;
    kind  <= k;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (busy);
    pending_results.push_back(want);
    items_sent++;
    kind_seen[k]++;
    if (want.status == rau_pkg::STATUS_ZERO) zero_den_seen++;
    if (want.status == rau_pkg::STATUS_OVF) overflow_seen++;
  endtask

  // Random gap before the next item: mostly none, sometimes a short one,
  // now and then a long one so that gaps land in every phase of the gcd.
  task automatic idle_gap();
    int pick, len;
    pick = $urandom_range(99);
    if (pick < 65) len = 0;
    else if (pick < 93) len = $urandom_range(3, 1);
    else len = $urandom_range(400, 10);
    if (len > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (len - 1) @(negedge clk);
    end
  endtask

  // Operand values drawn from several shapes: full range, small, edge values
  // and products of two random factors so that the gcd has work to cancel.
  function automatic logic [31:0] random_operand();
    int pick;
    logic [31:0] f;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return $urandom();
    end else if (pick < 60) begin
      f = $urandom_range(40);
      return $urandom_range(1) ? -f : f;
    end else if (pick < 70) begin
      case ($urandom_range(5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0001;
        4: return 32'h8000_0001;
        default: return 32'h0000_0000;
      endcase
    end else begin
      f = $urandom_range(5000, 1) * $urandom_range(3000, 1);
      return $urandom_range(1) ? -f : f;
    end
  endfunction

  function automatic logic [2:0] random_kind();
    if ($urandom_range(19) == 0) return 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
    return 3'($urandom_range(rau_pkg::KIND_CMP, rau_pkg::KIND_NORM));
  endfunction

  // Extremes of every field, every kind and each special case.
  task automatic test_directed();
    send_item(rau_pkg::KIND_NORM, 32'd6, 32'hffff_fff7, 32'd0, 32'd0);        // 6/-9 is -2/3
    send_item(rau_pkg::KIND_NORM, 32'd0, 32'd7, 32'd0, 32'd0);                 // zero gives 0/1
    send_item(rau_pkg::KIND_NORM, 32'd5, 32'd0, 32'd1, 32'd1);                 // zero denominator
    send_item(rau_pkg::KIND_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd0);         // most negative
    send_item(rau_pkg::KIND_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0); // +2^31 overflows
    send_item(rau_pkg::KIND_NORM, 32'd3, 32'h8000_0000, 32'd0, 32'd0);         // denominator 2^31
    send_item(rau_pkg::KIND_NORM, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'd0);
    send_item(rau_pkg::KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(rau_pkg::KIND_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);          // sum overflows
    send_item(rau_pkg::KIND_ADD, 32'd1, 32'd3, 32'd1, 32'd0);                  // b den zero
    send_item(rau_pkg::KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);                  // difference zero
    send_item(rau_pkg::KIND_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
    send_item(rau_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'd3);
    send_item(rau_pkg::KIND_MUL, 32'h7fff_ffff, 32'd1, 32'd2, 32'd1);
    send_item(rau_pkg::KIND_DIV, 32'd3, 32'd4, 32'd0, 32'd5);                  // division by zero
    send_item(rau_pkg::KIND_DIV, 32'hffff_fffd, 32'd4, 32'hffff_fffb, 32'hffff_fff9);
    send_item(rau_pkg::KIND_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
    send_item(rau_pkg::KIND_CMP, 32'd2, 32'd4, 32'hffff_ffff, 32'hffff_fffe);  // equal
    send_item(rau_pkg::KIND_CMP, 32'd1, 32'hffff_fffd, 32'd1, 32'd2);          // negative den
    send_item(rau_pkg::KIND_CMP, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(rau_pkg::KIND_CMP, 32'd1, 32'd1, 32'd1, 32'd0);                  // zero status
    send_item(KIND_SPARE_LO, 32'd4, 32'd8, 32'd9, 32'd0);                      // acts as normalize
    send_item(KIND_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
    idle_gap();
  endtask

  // Random items; short operands dominate so the long gcd stays the minority.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_kind(), random_operand(), random_operand(),
                random_operand(), random_operand());
      idle_gap();
    end
  endtask

  // Back-to-back items with start held high fill the two-entry queue and
  // keep busy asserted for long stretches.
  task automatic test_back_to_back(int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_kind(), random_operand(), random_operand(),
                random_operand(), random_operand());
    end
    idle_gap();
  endtask

  // Every result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    fraction_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing outstanding: num %h den %h status %0d order %0d",
                 $time, res_num, res_den, status, order);
      end else begin
        want = pending_results.pop_front();
        if (res_num !== want.num || res_den !== want.den ||
            status !== want.status || order !== want.order) begin
          mismatch_count++;
          $display("%0t: expected num %h den %h status %0d order %0d", $time,
                   want.num, want.den, want.status, want.order);
          $display("%0t: actual   num %h den %h status %0d order %0d", $time,
                   res_num, res_den, status, order);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    zero_den_seen = 0;
    overflow_seen = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    rst   = 1'b1;
    start = 1'b0;
    kind  = rau_pkg::KIND_NORM;
    a_num = '0;
    a_den = '0;
    b_num = '0;
    b_den = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(1200);
    test_back_to_back(300);

    @(negedge clk);
    start <= 1'b0;
    // The last result may still be deep in the gcd loop.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d items (kinds 0-7: %0d %0d %0d %0d %0d %0d %0d %0d), checked %0d results.",
             items_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7], results_seen);
    $display("Zero-denominator results: %0d, overflow results: %0d, mismatches: %0d.",
             zero_den_seen, overflow_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
